// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, constants and the character classifier for the base64url
// stream decoder. No dependencies.
`default_nettype none

package b64d_pkg;

  // Default width of the saturating byte counter
  localparam int COUNT_WIDTH_DEFAULT = 16;
  // Width of the reported byte total
  localparam int TOTAL_W = 16;
  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_LONE     = 2'd2;
  localparam logic [1:0] ST_TRAIL    = 2'd3;

  // Classified character as it travels through the queue
  typedef struct packed {
    logic [5:0] sextet;
    logic       bad;
    logic       last;
  } b64d_item_t;

  localparam int ITEM_W = $bits(b64d_item_t);

  // Map an ASCII code to its 6-bit value; bad is set outside the alphabet
  function automatic b64d_item_t classify(input logic [7:0] c, input logic last);
    b64d_item_t r;
    r.last   = last;
    r.bad    = 1'b0;
    r.sextet = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2D) begin
      r.sextet = 6'd62;
    end else if (c == 8'h5F) begin
      r.sextet = 6'd63;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64d_front.sv =====
// Front end: accepts input transactions and classifies each character.
// Depends on b64d_pkg.
`default_nettype none

module b64d_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        char_code,
  input  wire logic              is_last,
  input  wire logic              q_full,
  output logic                   push,
  output b64d_pkg::b64d_item_t   push_item
);
  import b64d_pkg::*;

  // Take a transaction whenever the queue has room
  assign in_ready  = !q_full;
  assign push      = in_valid && !q_full;
  assign push_item = classify(char_code, is_last);

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_queue.sv =====
// Small register queue that decouples the front end from the back end.
// Depends on b64d_pkg.
`default_nettype none

module b64d_queue #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH,
  parameter int WIDTH = b64d_pkg::ITEM_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      dout
);
  import b64d_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign dout      = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_back.sv =====
// Back end: decode state update and registered result stage.
// Depends on b64d_pkg.
`default_nettype none

module b64d_back #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_not_empty,
  input  wire b64d_pkg::b64d_item_t   q_item,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_byte,
  output logic                        byte_valid,
  output logic                        string_done,
  output logic [1:0]                  status,
  output logic [b64d_pkg::TOTAL_W-1:0] byte_total
);
  import b64d_pkg::*;

  logic [1:0]             group_phase, group_phase_next;
  logic [7:0]             carry_bits, carry_bits_next;
  logic [1:0]             error_code, error_code_next;
  logic [COUNT_WIDTH-1:0] byte_count, byte_count_next;
  logic [7:0]             dec_byte;
  logic                   have_byte;
  logic                   give_byte;
  logic [1:0]             err_mid;
  logic [TOTAL_W-1:0]     total_next;

  // Take the queue head whenever the result register is free or draining
  assign pop = q_not_empty && (!out_valid || out_ready);

  // Decode step for the head item
  always_comb begin
    group_phase_next = group_phase;
    carry_bits_next  = carry_bits;
    err_mid          = error_code;
    dec_byte         = 8'h00;
    have_byte        = 1'b0;
    if (q_item.bad) begin
      if (error_code == ST_OK) err_mid = ST_BAD_CHAR;
    end else begin
      unique case (group_phase)
        2'd0: begin
          if (q_item.last && error_code == ST_OK) err_mid = ST_LONE;
          carry_bits_next = {q_item.sextet, 2'b00};
        end
        2'd1: begin
          dec_byte        = carry_bits | {6'b0, q_item.sextet[5:4]};
          carry_bits_next = {q_item.sextet[3:0], 4'b0000};
          have_byte       = 1'b1;
        end
        2'd2: begin
          dec_byte        = carry_bits | {4'b0, q_item.sextet[5:2]};
          carry_bits_next = {q_item.sextet[1:0], 6'b000000};
          have_byte       = 1'b1;
        end
        default: begin
          dec_byte        = carry_bits | {2'b0, q_item.sextet};
          carry_bits_next = 8'h00;
          have_byte       = 1'b1;
        end
      endcase
      group_phase_next = group_phase + 2'd1;
    end
    give_byte = have_byte && (err_mid == ST_OK);
    byte_count_next = byte_count;
    if (give_byte && byte_count != '1) byte_count_next = byte_count + 1'b1;
    error_code_next = err_mid;
    if (q_item.last && err_mid == ST_OK && carry_bits_next != 8'h00) begin
      error_code_next = ST_TRAIL;
    end
  end

  // Reported total, limited to the output width
  generate
    if (COUNT_WIDTH > TOTAL_W) begin : g_total_sat
      assign total_next = (|byte_count_next[COUNT_WIDTH-1:TOTAL_W]) ? '1
                          : byte_count_next[TOTAL_W-1:0];
    end else if (COUNT_WIDTH == TOTAL_W) begin : g_total_eq
      assign total_next = byte_count_next;
    end else begin : g_total_ext
      assign total_next = {{(TOTAL_W - COUNT_WIDTH){1'b0}}, byte_count_next};
    end
  endgenerate

  // Decoder state; clears at the end of each string
  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= '0;
      carry_bits  <= '0;
      error_code  <= ST_OK;
      byte_count  <= '0;
    end else if (pop) begin
      if (q_item.last) begin
        group_phase <= '0;
        carry_bits  <= '0;
        error_code  <= ST_OK;
        byte_count  <= '0;
      end else begin
        group_phase <= group_phase_next;
        carry_bits  <= carry_bits_next;
        error_code  <= error_code_next;
        byte_count  <= byte_count_next;
      end
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte    <= give_byte ? dec_byte : 8'h00;
      byte_valid  <= give_byte;
      string_done <= q_item.last;
      status      <= error_code_next;
      byte_total  <= total_next;
    end
  end

  // End of string returns all state to zero
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    pop && q_item.last |=> group_phase == '0 && carry_bits == '0 &&
                           error_code == ST_OK && byte_count == '0)
    else $error("decoder state not cleared after last character");

  // A byte is only reported ok, or on a final character that adds trailing bits
  a_byte_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> status == ST_OK || string_done)
    else $error("byte reported with an error status");

  // Recorded error is sticky within a string
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_code != ST_OK && !(pop && q_item.last) |=> error_code == $past(error_code))
    else $error("recorded error changed mid-string");

  // Byte count never falls within a string
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_item.last) |=> byte_count >= $past(byte_count))
    else $error("byte count decreased mid-string");

endmodule

`default_nettype wire

// ===== hw/rtl/base64url_stream_decoder_core.sv =====
// Top level of the base64url stream decoder: front end, queue, back end.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
`default_nettype none

// Decodes unpadded base64url (A-Z a-z 0-9 - _) one character per transaction
// and returns exactly one result per character: a byte on the second to fourth
// character of each group of four, the sticky status of the string and a
// saturating byte total. The character flagged is_last closes the string,
// carries the final status and clears all decoder state. Sustained rate is one
// character per clock while out_ready holds. A two-entry queue sits between
// classifier and back end, and the result register accepts new work in the same
// cycle its transaction is taken, so a stall on one side stops the other only
// once the queue is full or empty. Characters are written into the queue, and
// result valid is registered when the back end takes them from the queue.
module base64url_stream_decoder_core #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              char_code,
  input  wire logic                    is_last,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [7:0]                   out_byte,
  output logic                         byte_valid,
  output logic                         string_done,
  output logic [1:0]                   status,
  output logic [b64d_pkg::TOTAL_W-1:0] byte_total
);
  import b64d_pkg::*;

  logic       push;
  b64d_item_t push_item;
  logic       q_full;
  logic       q_not_empty;
  b64d_item_t q_item;
  logic       pop;

  // Classify incoming characters
  b64d_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .is_last   (is_last),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .dout      (q_item)
  );

  // Decode and result stage
  b64d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_item      (q_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .string_done (string_done),
    .status      (status),
    .byte_total  (byte_total)
  );

endmodule

`default_nettype wire
